@@ rtl/core/homogeneous_point_transform_unit_defines.svh @@
// Assertion macros for the homogeneous point transform unit.
// Expects clk and rst_n in the scope of each use.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every edge outside reset.
`define HPTU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every edge outside reset.
`define HPTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/hptu_pkg.sv @@
// Package for the homogeneous point transform unit: beat types and constants.
// No dependencies.
`default_nettype none
package hptu_pkg;

    localparam int unsigned ACC_W       = 66;
    localparam int unsigned DIV_W       = 98;
    localparam int unsigned Q_W         = 32;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_XFORM = 2'd2
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [1:0]         row;
        logic [1:0]         column;
        logic signed [31:0] coefficient;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } request_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] read_value;
        logic               w_zero;
        logic               saturated;
    } result_t;

    // Row sums handed from the front to the back.
    typedef struct packed {
        logic                   is_read;
        logic [31:0]            read_value;
        logic [3:0][ACC_W-1:0]  acc;
    } xfer_t;

    typedef struct packed {
        logic [DIV_W-1:0] n;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             sat;
    } lane_t;

    typedef struct packed {
        logic               is_read;
        logic               w_zero;
        logic [31:0]        read_value;
        logic [DIV_W-1:0]   d;
        logic [2:0]         unused_pad;
        lane_t [2:0]        lane;
    } div_stage_t;

endpackage
`default_nettype wire

@@ rtl/core/hptu_front.sv @@
// Front end: takes request beats, holds the matrix, multiplies and sums rows.
// Depends on hptu_pkg.
`default_nettype none
module hptu_front
    import hptu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire request_t request,
    input  wire logic     q_full,
    output logic          q_push,
    output xfer_t         q_data
);

    logic [15:0][31:0]         matrix_reg;
    logic                      p_valid_reg, s1_valid_reg, s2_valid_reg;
    logic                      p_read_reg, s1_read_reg, s2_read_reg;
    logic [31:0]               p_rv_reg, s1_rv_reg, s2_rv_reg;
    logic [3:0][2:0][63:0]     p_prod_reg;
    logic [3:0][31:0]          p_c3_reg;
    logic [3:0][64:0]          s1_a_reg, s1_b_reg;
    logic [3:0][ACC_W-1:0]     s2_acc_reg;
    logic [3:0][2:0][63:0]     prod_next;
    logic [2:0][31:0]          pt;
    logic                      adv, accept, keep;

    assign adv    = !(s2_valid_reg && q_full);
    assign full   = !adv;
    assign accept = push && !full;
    assign keep   = (request.operation == OP_READ) || (request.operation == OP_XFORM);

    always_comb
    begin
        pt[0] = request.point_x;
        pt[1] = request.point_y;
        pt[2] = request.point_z;
        for (int r = 0; r < 4; r++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[r][j] = $signed({{32{matrix_reg[r*4+j][31]}}, matrix_reg[r*4+j]})
                                * $signed({{32{pt[j][31]}}, pt[j]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                matrix_reg[i] <= (i % 5 == 0) ? ONE_Q16 : 32'h0;
            end
            p_valid_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && request.operation == OP_WRITE)
            begin
                matrix_reg[{request.row, request.column}] <= request.coefficient;
            end
            if (adv)
            begin
                p_valid_reg  <= accept && keep;
                s1_valid_reg <= p_valid_reg;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_read_reg  <= (request.operation == OP_READ);
            p_rv_reg    <= matrix_reg[{request.row, request.column}];
            p_prod_reg  <= prod_next;
            for (int r = 0; r < 4; r++)
            begin
                p_c3_reg[r] <= matrix_reg[r*4+3];
            end
            s1_read_reg <= p_read_reg;
            s1_rv_reg   <= p_rv_reg;
            for (int r = 0; r < 4; r++)
            begin
                s1_a_reg[r] <= $signed({p_prod_reg[r][0][63], p_prod_reg[r][0]})
                             + $signed({p_prod_reg[r][1][63], p_prod_reg[r][1]});
                s1_b_reg[r] <= $signed({p_prod_reg[r][2][63], p_prod_reg[r][2]})
                             + $signed({{17{p_c3_reg[r][31]}}, p_c3_reg[r], 16'h0});
            end
            s2_read_reg <= s1_read_reg;
            s2_rv_reg   <= s1_rv_reg;
            for (int r = 0; r < 4; r++)
            begin
                s2_acc_reg[r] <= $signed({s1_a_reg[r][64], s1_a_reg[r]})
                               + $signed({s1_b_reg[r][64], s1_b_reg[r]});
            end
        end
    end

    assign q_push             = s2_valid_reg && !q_full;
    assign q_data.is_read     = s2_read_reg;
    assign q_data.read_value  = s2_rv_reg;
    assign q_data.acc         = s2_acc_reg;

endmodule
`default_nettype wire

@@ rtl/core/hptu_queue.sv @@
// Short queue of row-sum beats between front and back.
// Depends on hptu_pkg.
`default_nettype none
module hptu_queue
    import hptu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire xfer_t wr_data,
    output logic       q_full,
    input  wire logic  rd_en,
    output logic       q_empty,
    output xfer_t      rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    xfer_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/hptu_back.sv @@
// Back end: pipelined restoring divide of x, y, z by w, saturate, result register.
// Depends on hptu_pkg.
`default_nettype none
module hptu_back
    import hptu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire xfer_t q_data,
    output logic       q_pop,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    div_stage_t         st_reg    [Q_W+1];
    logic [Q_W:0]       st_valid_reg;
    div_stage_t         st_next   [Q_W+1];
    result_t            result_reg, result_next;
    logic               out_valid_reg;
    logic               adv;

    assign adv   = !out_valid_reg || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !out_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        logic [ACC_W-1:0] mag_d, mag_n;
        logic [DIV_W-1:0] t;
        mag_d = q_data.acc[3][ACC_W-1] ? (~q_data.acc[3] + 1'b1) : q_data.acc[3];
        st_next[0].is_read    = q_data.is_read;
        st_next[0].w_zero     = (q_data.acc[3] == '0);
        st_next[0].read_value = q_data.read_value;
        st_next[0].d          = DIV_W'(mag_d);
        st_next[0].unused_pad = '0;
        for (int l = 0; l < 3; l++)
        begin
            mag_n = q_data.acc[l][ACC_W-1] ? (~q_data.acc[l] + 1'b1) : q_data.acc[l];
            st_next[0].lane[l].n   = DIV_W'({mag_n, 16'h0});
            st_next[0].lane[l].q   = '0;
            st_next[0].lane[l].neg = q_data.acc[l][ACC_W-1] ^ q_data.acc[3][ACC_W-1];
            st_next[0].lane[l].sat = (DIV_W'({mag_n, 16'h0}) >= (DIV_W'(mag_d) << Q_W));
        end
        // One quotient bit per stage, most significant first.
        for (int i = 0; i < Q_W; i++)
        begin
            st_next[i+1] = st_reg[i];
            for (int l = 0; l < 3; l++)
            begin
                t = st_reg[i].d << (Q_W - 1 - i);
                if (!st_reg[i].lane[l].sat && st_reg[i].lane[l].n >= t)
                begin
                    st_next[i+1].lane[l].n = st_reg[i].lane[l].n - t;
                    st_next[i+1].lane[l].q[Q_W-1-i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [31:0] v [3];
        logic        s [3];
        div_stage_t  f;
        f = st_reg[Q_W];
        for (int l = 0; l < 3; l++)
        begin
            s[l] = 1'b1;
            if (f.lane[l].sat)
            begin
                v[l] = f.lane[l].neg ? SAT_NEG : SAT_POS;
            end
            else if (!f.lane[l].neg && f.lane[l].q > SAT_POS)
            begin
                v[l] = SAT_POS;
            end
            else if (f.lane[l].neg && f.lane[l].q > SAT_NEG)
            begin
                v[l] = SAT_NEG;
            end
            else
            begin
                s[l] = 1'b0;
                v[l] = f.lane[l].neg ? (~f.lane[l].q + 1'b1) : f.lane[l].q;
            end
        end
        result_next = '0;
        if (f.is_read)
        begin
            result_next.read_value = f.read_value;
        end
        else if (f.w_zero)
        begin
            result_next.w_zero = 1'b1;
        end
        else
        begin
            result_next.out_x     = v[0];
            result_next.out_y     = v[1];
            result_next.out_z     = v[2];
            result_next.saturated = s[0] || s[1] || s[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_valid_reg  <= {st_valid_reg[Q_W-1:0], !q_empty};
            out_valid_reg <= st_valid_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= Q_W; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            result_reg <= result_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/homogeneous_point_transform_unit.sv @@
// Path from accepting a request beat to its result: accept register, 2 more multiply/sum
// stages, 1 queue slot, 1 setup, 32 divide stages, 1 result register.
// Throughput: one beat per cycle when not stalled; 32 divide stages set latency, not rate.
// Coefficient writes take effect at acceptance and give no result beat.
// Reset (rst_n low, asynchronous): matrix goes to identity, all pipes and queue empty.
// Only full and empty carry backpressure; a stalled result stalls the divider first.
`default_nettype none
`include "homogeneous_point_transform_unit_defines.svh"
module homogeneous_point_transform_unit
    import hptu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire request_t request,
    output logic          empty,
    input  wire logic     pop,
    output result_t       result
);

    logic  q_full, q_empty, q_push, q_pop;
    xfer_t q_wr_data, q_rd_data;

    // Accept, update matrix, form the four row sums.
    hptu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    // Decouple front and back.
    hptu_queue #(.DEPTH(DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_rd_data)
    );

    // Divide by w, saturate, hold the result beat.
    hptu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    `HPTU_ASSERT_NOW(a_wzero_clears, !empty && result.w_zero,
        result.out_x == 0 && result.out_y == 0 && result.out_z == 0 && !result.saturated,
        "w_zero result carries nonzero data")
    `HPTU_ASSERT_NOW(a_read_only, !empty && result.read_value != 0,
        !result.w_zero && !result.saturated && result.out_x == 0,
        "read result mixed with transform data")
    `HPTU_ASSERT_NOW(a_sat_not_wzero, !empty && result.saturated,
        !result.w_zero && result.read_value == 0,
        "saturated flag on non-transform result")

endmodule
`default_nettype wire
